/* hdl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/epi_pkg.sv */
`default_nettype none
package epi_pkg;

   localparam int unsigned TOL_W = 16;
   localparam int unsigned REQ_W = 384;
   localparam int unsigned RSP_W = 104;
   localparam int unsigned QUO_W = 48;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [32:0] diff_type;

   typedef enum logic [1:0] {
      CNT_NONE = 2'd0,
      CNT_ONE  = 2'd1,
      CNT_PAIR = 2'd2
   } cnt_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } vec_type;

   // One queued result group: p0 for none/one/pair-start, p1 for pair-end
   typedef struct packed {
      cnt_type cnt;
      vec_type p0;
      vec_type p1;
   } entry_type;

   // Fields carried alongside the divider
   typedef struct packed {
      cnt_type  cls;
      vec_type  s;
      vec_type  e;
      diff_type dx;
      diff_type dy;
      diff_type dz;
   } side_type;

   // Clamp to the signed 32-bit range
   function automatic coord_type sat32(input logic signed [64:0] v);
      coord_type r;
      if (v > 65'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -65'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q16.16 product, floor shift, saturate
   function automatic coord_type qmul(input diff_type a, input coord_type b);
      logic signed [64:0] p;
      p = 65'(a) * 65'(b);
      return sat32(p >>> 16);
   endfunction

endpackage
`default_nettype wire

/* hdl/epi_div.sv */
`default_nettype none
module epi_div (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    en,
   input  wire                    in_valid,
   input  wire [47:0]             in_dividend,
   input  wire [31:0]             in_divisor,
   input  wire                    in_qneg,
   input  epi_pkg::side_type      in_side,
   output logic                   out_valid,
   output logic [47:0]            out_quotient,
   output logic                   out_qneg,
   output epi_pkg::side_type      out_side
);
   import epi_pkg::*;

   logic        vld_w  [0:QUO_W];
   logic [31:0] rem_w  [0:QUO_W];
   logic [47:0] num_w  [0:QUO_W];
   logic [31:0] div_w  [0:QUO_W];
   logic        neg_w  [0:QUO_W];
   side_type    side_w [0:QUO_W];

   assign vld_w[0]  = in_valid;
   assign rem_w[0]  = '0;
   assign num_w[0]  = in_dividend;
   assign div_w[0]  = in_divisor;
   assign neg_w[0]  = in_qneg;
   assign side_w[0] = in_side;

   // One restoring step per stage; quotient bits shift in behind the dividend
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic        vld_ff;
      logic [31:0] rem_ff;
      logic [47:0] num_ff;
      logic [31:0] div_ff;
      logic        neg_ff;
      side_type    side_ff;
      logic [32:0] trial;
      logic [32:0] diff;
      logic        take;
      logic [31:0] rem_in;

      always_comb begin
         trial  = {rem_w[k], num_w[k][47]};
         diff   = trial - {1'b0, div_w[k]};
         take   = trial >= {1'b0, div_w[k]};
         rem_in = take ? diff[31:0] : trial[31:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            num_ff  <= {num_w[k][46:0], take};
            div_ff  <= div_w[k];
            neg_ff  <= neg_w[k];
            side_ff <= side_w[k];
         end
      end

      assign vld_w[k+1]  = vld_ff;
      assign rem_w[k+1]  = rem_ff;
      assign num_w[k+1]  = num_ff;
      assign div_w[k+1]  = div_ff;
      assign neg_w[k+1]  = neg_ff;
      assign side_w[k+1] = side_ff;
   end

   assign out_valid    = vld_w[QUO_W];
   assign out_quotient = num_w[QUO_W];
   assign out_qneg     = neg_w[QUO_W];
   assign out_side     = side_w[QUO_W];

endmodule
`default_nettype wire

/* hdl/epi_front.sv */
`default_nettype none
module epi_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire                          in_valid,
   input  wire [epi_pkg::REQ_W-1:0]     in_data,
   input  wire [epi_pkg::TOL_W-1:0]     tolerance,
   output logic                         out_valid,
   output epi_pkg::entry_type           out_entry
);
   import epi_pkg::*;

   // Stage A: differences
   logic     a_vld_ff;
   vec_type  a_s_ff, a_e_ff;
   coord_type a_n_ff [0:2];
   diff_type a_da_ff [0:2];
   diff_type a_db_ff [0:2];
   diff_type a_dir_ff [0:2];
   diff_type a_v_ff [0:2];

   // Stage B: saturated products
   logic     b_vld_ff;
   vec_type  b_s_ff, b_e_ff;
   diff_type b_dir_ff [0:2];
   coord_type b_pa_ff [0:2];
   coord_type b_pb_ff [0:2];
   coord_type b_pd_ff [0:2];
   coord_type b_pv_ff [0:2];

   // Stage C: dot products
   logic      c_vld_ff;
   vec_type   c_s_ff, c_e_ff;
   diff_type  c_dir_ff [0:2];
   coord_type c_dista_ff, c_distb_ff, c_d_ff, c_num_ff;

   // Stage D: classify, divider setup
   logic        d_vld_ff;
   logic [47:0] d_dividend_ff;
   logic [31:0] d_divisor_ff;
   logic        d_qneg_ff;
   side_type    d_side_ff;

   // Divider outputs
   logic        q_vld;
   logic [47:0] q_mag;
   logic        q_neg;
   side_type    q_side;

   // Stage E: saturated ratio
   logic      e_vld_ff;
   coord_type e_t_ff;
   side_type  e_side_ff;

   // Stage F: direction times ratio
   logic      f_vld_ff;
   coord_type f_p_ff [0:2];
   side_type  f_side_ff;

   coord_type in_s [0:2];
   coord_type in_e [0:2];
   coord_type in_o [0:2];
   coord_type in_n [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_s[i] = in_data[32*i +: 32];
         in_e[i] = in_data[96 + 32*i +: 32];
         in_o[i] = in_data[192 + 32*i +: 32];
         in_n[i] = in_data[288 + 32*i +: 32];
      end
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= q_vld;
         f_vld_ff <= e_vld_ff;
      end
   end

   // Stage A
   always_ff @(posedge clock) begin
      if (en) begin
         a_s_ff <= '{z: in_s[2], y: in_s[1], x: in_s[0]};
         a_e_ff <= '{z: in_e[2], y: in_e[1], x: in_e[0]};
         for (int i = 0; i < 3; i++) begin
            a_n_ff[i]   <= in_n[i];
            a_da_ff[i]  <= 33'(in_s[i]) - 33'(in_o[i]);
            a_db_ff[i]  <= 33'(in_e[i]) - 33'(in_o[i]);
            a_dir_ff[i] <= 33'(in_e[i]) - 33'(in_s[i]);
            a_v_ff[i]   <= 33'(in_o[i]) - 33'(in_s[i]);
         end
      end
   end

   // Stage B
   always_ff @(posedge clock) begin
      if (en) begin
         b_s_ff <= a_s_ff;
         b_e_ff <= a_e_ff;
         for (int i = 0; i < 3; i++) begin
            b_dir_ff[i] <= a_dir_ff[i];
            b_pa_ff[i]  <= qmul(a_da_ff[i], a_n_ff[i]);
            b_pb_ff[i]  <= qmul(a_db_ff[i], a_n_ff[i]);
            b_pd_ff[i]  <= qmul(a_dir_ff[i], a_n_ff[i]);
            b_pv_ff[i]  <= qmul(a_v_ff[i], a_n_ff[i]);
         end
      end
   end

   // Stage C
   always_ff @(posedge clock) begin
      if (en) begin
         c_s_ff     <= b_s_ff;
         c_e_ff     <= b_e_ff;
         c_dir_ff   <= b_dir_ff;
         c_dista_ff <= sat32(65'(b_pa_ff[0]) + 65'(b_pa_ff[1]) + 65'(b_pa_ff[2]));
         c_distb_ff <= sat32(65'(b_pb_ff[0]) + 65'(b_pb_ff[1]) + 65'(b_pb_ff[2]));
         c_d_ff     <= sat32(65'(b_pd_ff[0]) + 65'(b_pd_ff[1]) + 65'(b_pd_ff[2]));
         c_num_ff   <= sat32(65'(b_pv_ff[0]) + 65'(b_pv_ff[1]) + 65'(b_pv_ff[2]));
      end
   end

   // Stage D: classify
   logic     d_nohit, d_flat;
   diff_type d_abs, d_nabs;
   side_type d_side_in;

   always_comb begin
      d_nohit = (c_dista_ff > 0 && c_distb_ff > 0) || (c_dista_ff < 0 && c_distb_ff < 0);
      d_abs   = c_d_ff[31] ? -33'(c_d_ff) : 33'(c_d_ff);
      d_nabs  = c_num_ff[31] ? -33'(c_num_ff) : 33'(c_num_ff);
      d_flat  = d_abs <= 33'(tolerance);
      d_side_in.s  = c_s_ff;
      d_side_in.e  = c_e_ff;
      d_side_in.dx = c_dir_ff[0];
      d_side_in.dy = c_dir_ff[1];
      d_side_in.dz = c_dir_ff[2];
      if (d_nohit) begin
         d_side_in.cls = CNT_NONE;
      end else if (d_flat) begin
         d_side_in.cls = CNT_PAIR;
      end else begin
         d_side_in.cls = CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_dividend_ff <= {d_nabs[31:0], 16'h0000};
         d_divisor_ff  <= d_abs[31:0];
         d_qneg_ff     <= c_num_ff[31] ^ c_d_ff[31];
         d_side_ff     <= d_side_in;
      end
   end

   epi_div u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (d_vld_ff),
      .in_dividend  (d_dividend_ff),
      .in_divisor   (d_divisor_ff),
      .in_qneg      (d_qneg_ff),
      .in_side      (d_side_ff),
      .out_valid    (q_vld),
      .out_quotient (q_mag),
      .out_qneg     (q_neg),
      .out_side     (q_side)
   );

   // Stage E: sign and clamp the ratio
   coord_type e_t_in;

   always_comb begin
      if (!q_neg) begin
         e_t_in = (q_mag > 48'd2147483647) ? 32'sh7fffffff : q_mag[31:0];
      end else begin
         e_t_in = (q_mag > 48'd2147483648) ? 32'sh80000000 : -q_mag[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_t_ff    <= e_t_in;
         e_side_ff <= q_side;
      end
   end

   // Stage F
   always_ff @(posedge clock) begin
      if (en) begin
         f_p_ff[0] <= qmul(e_side_ff.dx, e_t_ff);
         f_p_ff[1] <= qmul(e_side_ff.dy, e_t_ff);
         f_p_ff[2] <= qmul(e_side_ff.dz, e_t_ff);
         f_side_ff <= e_side_ff;
      end
   end

   // Build the queue entry
   vec_type pt;

   always_comb begin
      pt.x = sat32(65'(f_side_ff.s.x) + 65'(f_p_ff[0]));
      pt.y = sat32(65'(f_side_ff.s.y) + 65'(f_p_ff[1]));
      pt.z = sat32(65'(f_side_ff.s.z) + 65'(f_p_ff[2]));
      out_entry.cnt = f_side_ff.cls;
      out_entry.p1  = f_side_ff.e;
      case (f_side_ff.cls)
         CNT_NONE: begin
            out_entry.p0 = '0;
         end
         CNT_PAIR: begin
            out_entry.p0 = f_side_ff.s;
         end
         default: begin
            out_entry.p0 = pt;
         end
      endcase
   end

   assign out_valid = f_vld_ff;

endmodule
`default_nettype wire

/* hdl/epi_queue.sv */
`default_nettype none
module epi_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  epi_pkg::entry_type  push_entry,
   input  wire                 pop,
   output logic                head_valid,
   output epi_pkg::entry_type  head_entry,
   output logic                full
);
   import epi_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   entry_type mem [0:DEPTH-1];
   logic [PW-1:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Advance pointers with wrap
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_entry;
      end
   end

   assign head_entry = mem[rd_ff];
   assign head_valid = cnt_ff != '0;
   assign full       = cnt_ff == CW'(DEPTH);

endmodule
`default_nettype wire

/* hdl/epi_back.sv */
`default_nettype none
module epi_back (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         head_valid,
   input  epi_pkg::entry_type          head_entry,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [epi_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tlast
);
   import epi_pkg::*;

   logic    phase_ff, phase_in;
   vec_type pt;
   logic    fire;

   // Pair entries give two items: start, then end
   always_comb begin
      pt         = phase_ff ? head_entry.p1 : head_entry.p0;
      rsp_tvalid = head_valid;
      rsp_tlast  = (head_entry.cnt != CNT_PAIR) || phase_ff;
      rsp_tdata  = {6'b0, pt.z, pt.y, pt.x, head_entry.cnt};
      fire       = rsp_tvalid && rsp_tready;
      pop        = fire && rsp_tlast;
      phase_in   = phase_ff;
      if (fire) begin
         phase_in = !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/edge_plane_intersection_unit.sv */
`default_nettype none
// Segment/plane intersection, signed Q16.16.
// req channel: one item = segment start, end, plane origin and normal.
// rsp channel: count 0 (no hit) or 1 (single point) gives one item; count 2
//   (segment in plane) gives two items, start then end, tlast on the second.
// csr channel: writes tiny_tolerance; reset value 1. Write only while idle.
// Throughput: one item per cycle while the pipeline is not held; a pair result gives two rsp items.
// Datapath: products, dot sums, classify, a 48-stage restoring divider
//   (one quotient bit per stage), ratio products, then a small result queue.
// When rsp stalls the queue fills; once full the whole pipeline holds and
//   req_tready drops until the queue frees a slot.
// Reset clears all valid state and the queue; nothing is in flight after.
module edge_plane_intersection_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                         clock,
   input  wire                         reset,
   // start_x..z, end_x..z, origin_x..z, normal_x..z from bit 0 up
   input  wire [epi_pkg::REQ_W-1:0]    req_tdata,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   // point_count, point_x, point_y, point_z from bit 0 up, zero fill
   output logic [epi_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [epi_pkg::TOL_W-1:0]    csr_data
);
   import epi_pkg::*;

   logic [TOL_W-1:0] tol_ff;
   logic             adv;
   logic             fr_valid;
   entry_type        fr_entry;
   logic             q_valid;
   entry_type        q_entry;
   logic             q_full;
   logic             q_pop;

   // Tolerance register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_W'(1);
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   // Hold the pipeline only when the queue cannot take its output
   assign adv        = !q_full || q_pop;
   assign req_tready = adv;

   epi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_tvalid && req_tready),
      .in_data   (req_tdata),
      .tolerance (tol_ff),
      .out_valid (fr_valid),
      .out_entry (fr_entry)
   );

   epi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fr_valid && adv),
      .push_entry (fr_entry),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_entry),
      .full       (q_full)
   );

   epi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_entry (q_entry),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

/* hdl/epi_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module epi_checker (
   input wire                         clock,
   input wire                         reset,
   input wire [epi_pkg::REQ_W-1:0]    req_tdata,
   input wire                         req_tvalid,
   input wire                         req_tready,
   input wire [epi_pkg::RSP_W-1:0]    rsp_tdata,
   input wire                         rsp_tlast,
   input wire                         rsp_tvalid,
   input wire                         rsp_tready,
   input wire                         csr_valid,
   input wire                         csr_ready,
   input wire [epi_pkg::TOL_W-1:0]    csr_data
);
   // A stalled item stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // A stalled item keeps its payload
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   // A miss is a lone item with a zero point
   `ASSERT_SAME(a_miss_zero, clock, reset, rsp_tvalid && rsp_tdata[1:0] == 2'd0,
      rsp_tlast && rsp_tdata[97:2] == 96'd0)
   // A single hit is always the last item of its group
   `ASSERT_SAME(a_one_last, clock, reset, rsp_tvalid && rsp_tdata[1:0] == 2'd1, rsp_tlast)
   // A pair start is followed by its pair end
   `ASSERT_NEXT(a_pair_end, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && rsp_tlast && rsp_tdata[1:0] == 2'd2)
endmodule

bind edge_plane_intersection_unit epi_checker u_epi_checker (.*);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import epi_pkg::*;

   typedef struct {
      logic [1:0]         count;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic               last;
   } point_rec;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                req_tvalid = 1'b0;
   wire                 req_tready;
   wire [RSP_W-1:0]     rsp_tdata;
   wire                 rsp_tlast;
   wire                 rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic                csr_valid = 1'b0;
   wire                 csr_ready;
   logic [TOL_W-1:0]    csr_data = '0;

   logic [REQ_W-1:0]    segment_queue[$];
   point_rec            expected_points[$];
   logic [15:0]         tolerance = 16'd1;
   int                  mismatches = 0;
   int                  cycle_count = 0;
   bit                  hold_send = 1'b0;
   bit                  calm = 1'b0;
   bit                  seen_tready = 1'b0;

   edge_plane_intersection_unit u_top (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // floor-shifted Q16.16 product, saturated
   function automatic longint fixmul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp32(p >>> 16);
   endfunction

   function automatic longint dot3(longint a0, longint a1, longint a2,
                                   longint b0, longint b1, longint b2);
      return clamp32(fixmul(a0, b0) + fixmul(a1, b1) + fixmul(a2, b2));
   endfunction

   // compute the intersection points of one segment against its plane
   task automatic predict_intersection(input logic [REQ_W-1:0] w);
      longint c[12];
      longint dist_a, dist_b, d, ad, num, t;
      longint pt[3];
      point_rec r;
      for (int i = 0; i < 12; i++) c[i] = longint'($signed(w[32*i +: 32]));
      dist_a = dot3(c[0]-c[6], c[1]-c[7], c[2]-c[8], c[9], c[10], c[11]);
      dist_b = dot3(c[3]-c[6], c[4]-c[7], c[5]-c[8], c[9], c[10], c[11]);
      if ((dist_a > 0 && dist_b > 0) || (dist_a < 0 && dist_b < 0)) begin
         r = '{CNT_NONE, 0, 0, 0, 1'b1};
         expected_points.push_back(r);
         return;
      end
      d = dot3(c[3]-c[0], c[4]-c[1], c[5]-c[2], c[9], c[10], c[11]);
      ad = d < 0 ? -d : d;
      if (ad <= longint'(tolerance)) begin
         r = '{CNT_PAIR, c[0][31:0], c[1][31:0], c[2][31:0], 1'b0};
         expected_points.push_back(r);
         r = '{CNT_PAIR, c[3][31:0], c[4][31:0], c[5][31:0], 1'b1};
         expected_points.push_back(r);
         return;
      end
      num = dot3(c[6]-c[0], c[7]-c[1], c[8]-c[2], c[9], c[10], c[11]);
      t = clamp32((num * 65536) / d);
      for (int i = 0; i < 3; i++) pt[i] = clamp32(c[i] + fixmul(c[3+i] - c[i], t));
      r = '{CNT_ONE, pt[0][31:0], pt[1][31:0], pt[2][31:0], 1'b1};
      expected_points.push_back(r);
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // drive segments from the queue; predict on accept
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_intersection(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (segment_queue.size() > 0 && !hold_send &&
                (calm || $urandom_range(99) >= 12)) begin
               req_tdata <= segment_queue.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // check points in order; stall the result side at random
   always @(posedge clock) begin
      point_rec e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected point item");
            end else begin
               e = expected_points.pop_front();
               if (rsp_tdata[1:0] !== e.count)
                  report_mismatch($sformatf("count %0d exp %0d", rsp_tdata[1:0], e.count));
               if (rsp_tdata[33:2] !== e.px)
                  report_mismatch($sformatf("x %h exp %h", rsp_tdata[33:2], e.px));
               if (rsp_tdata[65:34] !== e.py)
                  report_mismatch($sformatf("y %h exp %h", rsp_tdata[65:34], e.py));
               if (rsp_tdata[97:66] !== e.pz)
                  report_mismatch($sformatf("z %h exp %h", rsp_tdata[97:66], e.pz));
               if (rsp_tlast !== e.last)
                  report_mismatch($sformatf("last %0b exp %0b", rsp_tlast, e.last));
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 12);
      end
   end

   // end the run if it hangs
   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
         default: return 32'($signed($urandom_range(0, 262144)) - 131072);
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] make_segment(logic [31:0] c[12]);
      logic [REQ_W-1:0] w;
      for (int i = 0; i < 12; i++) w[32*i +: 32] = c[i];
      return w;
   endfunction

   task automatic wait_drained();
      while (segment_queue.size() > 0 || req_tvalid || expected_points.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [15:0] v);
      @(posedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tolerance = v;
   endtask

   task automatic random_phase(input int n);
      logic [31:0] c[12];
      int mode, kind;
      for (int k = 0; k < n; k++) begin
         mode = $urandom_range(2);
         for (int i = 0; i < 12; i++) c[i] = rand_coord(mode);
         kind = $urandom_range(9);
         // planes through a segment end (touching cases), and a zero normal
         if (kind < 2) begin
            for (int i = 0; i < 3; i++) c[6+i] = c[i];
            c[11] = 0;
            c[5] = c[2];
         end else if (kind < 3) begin
            for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
         end else if (kind < 4) begin
            c[9] = 0; c[10] = 0; c[11] = 0;
         end
         segment_queue.push_back(make_segment(c));
      end
   endtask

   initial begin
      logic [31:0] c[12];
      logic [31:0] mx = 32'h7fffffff, mn = 32'h80000000;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: crossing, misses, in plane, touching, zero normal, extremes
      c = '{0, 0, -65536, 0, 0, 65536, 0, 0, 0, 0, 0, 65536};
      segment_queue.push_back(make_segment(c));
      c = '{0, 0, 65536, 0, 0, 131072, 0, 0, 0, 0, 0, 65536};
      segment_queue.push_back(make_segment(c));
      c = '{0, 0, -65536, 0, 0, -131072, 0, 0, 0, 0, 0, 65536};
      segment_queue.push_back(make_segment(c));
      c = '{0, 0, 0, 65536, 65536, 0, 0, 0, 0, 0, 0, 65536};
      segment_queue.push_back(make_segment(c));
      c = '{0, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 0, 65536};
      segment_queue.push_back(make_segment(c));
      c = '{5, 6, 7, 8, 9, 10, 1, 2, 3, 0, 0, 0};
      segment_queue.push_back(make_segment(c));
      c = '{mn, mn, mn, mx, mx, mx, 0, 0, 0, mx, mx, mx};
      segment_queue.push_back(make_segment(c));
      c = '{mx, mx, mx, mn, mn, mn, mx, mn, 0, mn, mn, mn};
      segment_queue.push_back(make_segment(c));
      c = '{mn, mx, mn, mx, mn, mx, mn, mx, mn, mx, mn, mx};
      segment_queue.push_back(make_segment(c));
      c = '{0, 0, -1, 1, 0, 2, 0, 0, 0, 1, 0, 1};
      segment_queue.push_back(make_segment(c));
      c = '{mx, 0, mn, mn, 0, mx, 0, 0, 0, 0, 0, 1};
      segment_queue.push_back(make_segment(c));
      wait_drained();
      // tolerance sweep including both extremes
      write_tolerance(16'd0);
      random_phase(350);
      wait_drained();
      write_tolerance(16'hffff);
      calm = 1'b1;
      random_phase(350);
      wait_drained();
      calm = 1'b0;
      write_tolerance(16'($urandom()));
      random_phase(150);
      // hold the sender until all points arrive
      while (segment_queue.size() > 75) @(posedge clock);
      hold_send = 1'b1;
      while (req_tvalid || expected_points.size() > 0) @(posedge clock);
      hold_send = 1'b0;
      wait_drained();
      write_tolerance(16'd1);
      random_phase(500);
      wait_drained();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+hdl
hdl/epi_pkg.sv
hdl/epi_div.sv
hdl/epi_front.sv
hdl/epi_queue.sv
hdl/epi_back.sv
hdl/edge_plane_intersection_unit.sv
hdl/epi_checker.sv
tb/testbench.sv
